FILE: hdl/assert_macros.svh
// assertion macros used by the core rtl file
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked at every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

FILE: hdl/hbp_pkg.sv
// types, constants and commands of the huffman bit packer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package hbp_pkg;

   localparam int SYMBOL_COUNT_DEF = 256;
   localparam int MAX_CODE_LEN     = 32;
   localparam int WORD_W           = 32;
   localparam int ACC_W            = 7;
   localparam int COMB_W           = ACC_W + WORD_W;
   localparam int MAX_BYTES        = 4;
   localparam logic [5:0] LEN_LIMIT =
      6'((MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W);

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_ENC   = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [5:0]        len;
      logic [WORD_W-1:0] word;
   } entry_type;

   // table access issued at request accept
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic              rd_ok;
      logic [7:0]        idx;
      logic [5:0]        len;
      logic [WORD_W-1:0] word;
   } tbl_req_type;

   typedef struct packed {
      logic [2:0]                cnt;
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [3:0]                bits;
      logic                      upd;
      logic [ACC_W-1:0]          acc;
      logic [2:0]                fill;
   } pack_res_type;

endpackage
`default_nettype wire

FILE: hdl/hbp_code_table.sv
// code table memory with per-entry valid bits and registered read
// depends on hbp_pkg
`timescale 1ns / 1ps
`default_nettype none
module hbp_code_table #(
   parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hbp_pkg::tbl_req_type tbl_req,
   output hbp_pkg::entry_type       rd_entry,
   output logic                     rd_hit
);

   localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

   hbp_pkg::entry_type mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] vld_ff;
   logic [SYMBOL_COUNT-1:0] vld_in;
   hbp_pkg::entry_type rd_entry_ff;
   logic rd_hit_ff;
   logic rd_hit_in;
   hbp_pkg::entry_type wr_entry;
   logic [5:0] len_c;
   logic [AW-1:0] addr;

   assign addr = tbl_req.idx[AW-1:0];

   // length saturates, codeword bits above it are dropped
   always_comb begin
      len_c = (tbl_req.len > hbp_pkg::LEN_LIMIT) ? hbp_pkg::LEN_LIMIT : tbl_req.len;
      wr_entry.len = len_c;
      for (int i = 0; i < hbp_pkg::WORD_W; i++) begin
         wr_entry.word[i] = tbl_req.word[i] & (6'(i) < len_c);
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (tbl_req.wr_en) begin
         vld_in[addr] = 1'b1;
      end
      rd_hit_in = rd_hit_ff;
      if (tbl_req.rd_en) begin
         rd_hit_in = tbl_req.rd_ok & vld_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[addr] <= wr_entry;
      end
      if (tbl_req.rd_en) begin
         rd_entry_ff <= mem[addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_hit   = rd_hit_ff;

endmodule
`default_nettype wire

FILE: hdl/hbp_packer.sv
// combinational packing of one codeword or flush into up to four bytes
// depends on hbp_pkg
`timescale 1ns / 1ps
`default_nettype none
module hbp_packer (
   input  wire hbp_pkg::cmd_type         cmd,
   input  wire hbp_pkg::entry_type       entry,
   input  wire logic                     hit,
   input  wire logic [hbp_pkg::ACC_W-1:0] acc,
   input  wire logic [2:0]               fill,
   output hbp_pkg::pack_res_type         res
);

   logic [5:0] len;
   logic [5:0] total;
   logic [hbp_pkg::COMB_W-1:0] comb;
   logic [hbp_pkg::COMB_W-1:0] lj;

   always_comb begin
      len   = hit ? entry.len : 6'd0;
      comb  = (hbp_pkg::COMB_W'(acc) << len) | hbp_pkg::COMB_W'(entry.word);
      total = {3'd0, fill} + len;
      // left justify so byte k sits at a fixed place
      lj    = comb << (6'(hbp_pkg::COMB_W) - total);

      res = '0;
      res.acc  = acc;
      res.fill = fill;
      case (cmd)
         hbp_pkg::CMD_ENC: begin
            if (len != 6'd0) begin
               res.upd  = 1'b1;
               res.cnt  = total[5:3];
               res.bits = 4'd8;
               for (int k = 0; k < hbp_pkg::MAX_BYTES; k++) begin
                  res.bytes[k] = lj[hbp_pkg::COMB_W-1-8*k -: 8];
               end
               res.fill = total[2:0];
               for (int i = 0; i < hbp_pkg::ACC_W; i++) begin
                  res.acc[i] = comb[i] & (3'(i) < total[2:0]);
               end
            end
         end
         hbp_pkg::CMD_FLUSH: begin
            if (fill != 3'd0) begin
               res.upd      = 1'b1;
               res.cnt      = 3'd1;
               res.bits     = {1'b0, fill};
               res.bytes[0] = 8'({1'b0, acc} << (4'd8 - {1'b0, fill}));
               res.acc      = '0;
               res.fill     = 3'd0;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hdl/huffman_bit_packer_core.sv
// top level of the huffman bit packer: request stage, table, packer, result buffer
// depends on hbp_pkg, hbp_code_table, hbp_packer and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   direction  handshake            payload
//  req_      in         tvalid / tready      tuser command, tdata symbol/code
//  rsp_      out        tvalid / tready      tdata byte and bit count, tlast
//
//  a request is taken every cycle while results keep up; its table read is registered,
//  then it is packed into the result buffer
//  an encode makes 0 to 4 results, one per cycle while rsp_tready is high; a request
//  that makes n > 1 results holds the buffer; req_tready may drop until the last leaves
//  reset clears every table valid bit at once and empties the bit buffer
//  rsp_tready low stalls the result buffer, then the request stage, then req_tready
//
module huffman_bit_packer_core #(
   parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
   input  wire logic [47:0] req_tdata,
   // [1:0] command
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] out_byte, [11:8] valid_bits, [15:12] zero
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast
);

   `include "assert_macros.svh"

   // request side
   logic req_acc;
   hbp_pkg::cmd_type req_cmd;
   logic sym_ok;
   hbp_pkg::tbl_req_type tbl_req;

   // request stage, table data is registered inside the table
   logic s1_valid_ff, s1_valid_in;
   hbp_pkg::cmd_type s1_cmd_ff, s1_cmd_in;
   logic s1_go;
   hbp_pkg::entry_type rd_entry;
   logic rd_hit;

   // pending bits carried between codewords
   logic [hbp_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [2:0] fill_ff, fill_in;
   hbp_pkg::pack_res_type res;

   // result buffer, drained one byte per cycle while rsp_tready is high
   logic ob_valid_ff, ob_valid_in;
   logic [hbp_pkg::MAX_BYTES-1:0][7:0] ob_bytes_ff, ob_bytes_in;
   logic [3:0] ob_bits_ff, ob_bits_in;
   logic [2:0] ob_cnt_ff, ob_cnt_in;
   logic [1:0] ob_idx_ff, ob_idx_in;
   logic ob_last;
   logic rsp_acc;

   assign req_cmd = hbp_pkg::cmd_type'(req_tuser);
   assign req_acc = req_tvalid & req_tready;
   assign sym_ok  = {1'b0, req_tdata[7:0]} < 9'(SYMBOL_COUNT);

   always_comb begin
      tbl_req.wr_en = req_acc & (req_cmd == hbp_pkg::CMD_LOAD) & sym_ok;
      tbl_req.rd_en = req_acc;
      tbl_req.rd_ok = (req_cmd == hbp_pkg::CMD_ENC) & sym_ok;
      tbl_req.idx   = req_tdata[7:0];
      tbl_req.word  = req_tdata[39:8];
      tbl_req.len   = req_tdata[45:40];
   end

   hbp_code_table #(
      .SYMBOL_COUNT(SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_entry(rd_entry),
      .rd_hit  (rd_hit)
   );

   hbp_packer u_packer (
      .cmd  (s1_cmd_ff),
      .entry(rd_entry),
      .hit  (rd_hit),
      .acc  (acc_ff),
      .fill (fill_ff),
      .res  (res)
   );

   // result handshake
   assign rsp_acc = rsp_tvalid & rsp_tready;
   assign ob_last = ({1'b0, ob_idx_ff} == (ob_cnt_ff - 3'd1));
   // stage moves into the buffer when it is empty or its final byte leaves
   assign s1_go      = s1_valid_ff & (~ob_valid_ff | (rsp_acc & ob_last));
   assign req_tready = ~s1_valid_ff | s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cmd_in   = s1_cmd_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
         s1_cmd_in   = req_cmd;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      acc_in  = acc_ff;
      fill_in = fill_ff;
      if (s1_go & res.upd) begin
         acc_in  = res.acc;
         fill_in = res.fill;
      end

      ob_valid_in = ob_valid_ff;
      ob_bytes_in = ob_bytes_ff;
      ob_bits_in  = ob_bits_ff;
      ob_cnt_in   = ob_cnt_ff;
      ob_idx_in   = ob_idx_ff;
      if (s1_go) begin
         ob_valid_in = (res.cnt != 3'd0);
         ob_bytes_in = res.bytes;
         ob_bits_in  = res.bits;
         ob_cnt_in   = res.cnt;
         ob_idx_in   = 2'd0;
      end else if (rsp_acc) begin
         ob_idx_in = ob_idx_ff + 2'd1;
         if (ob_last) begin
            ob_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_cmd_ff   <= hbp_pkg::CMD_NONE;
         acc_ff      <= '0;
         fill_ff     <= 3'd0;
         ob_valid_ff <= 1'b0;
         ob_cnt_ff   <= 3'd0;
         ob_idx_ff   <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_cmd_ff   <= s1_cmd_in;
         acc_ff      <= acc_in;
         fill_ff     <= fill_in;
         ob_valid_ff <= ob_valid_in;
         ob_cnt_ff   <= ob_cnt_in;
         ob_idx_ff   <= ob_idx_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      ob_bytes_ff <= ob_bytes_in;
      ob_bits_ff  <= ob_bits_in;
   end

   assign rsp_tvalid = ob_valid_ff;
   assign rsp_tdata  = {4'd0, ob_bits_ff, ob_bytes_ff[ob_idx_ff]};
   assign rsp_tlast  = ob_last;

   // a full buffer always points inside its byte group
   `ASSERT_IMPLY(a_ob_range, clock, reset, ob_valid_ff, (ob_cnt_ff != 3'd0) && ({1'b0, ob_idx_ff} < ob_cnt_ff) && (ob_cnt_ff <= 3'd4), "result buffer index out of range")
   // pending bits above the fill count stay clear
   `ASSERT_ALWAYS(a_acc_clean, clock, reset, (acc_ff >> fill_ff) == '0, "stale bits above fill count")
   // a partial byte is only ever the last result of its request
   `ASSERT_IMPLY(a_partial_last, clock, reset, rsp_tvalid && (rsp_tdata[11:8] != 4'd8), rsp_tlast, "partial byte not last")
   // a flush leaves the bit buffer empty
   `ASSERT_NEXT(a_flush_empty, clock, reset, s1_go && (s1_cmd_ff == hbp_pkg::CMD_FLUSH), fill_ff == 3'd0, "flush left pending bits")

endmodule
`default_nettype wire
